>>> hw/rtl/rpr_pkg.sv
`timescale 1ns / 1ps

package rpr_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 8;
    localparam int FRAME_BITS = $clog2(FRAMES);
    localparam int CNT_BITS   = $clog2(FRAMES + 1);
    localparam int CFG_BITS   = 4;
    localparam int RND_BITS   = 16;
    localparam int DIGIT_BITS = 4;
    localparam int DIGITS     = RND_BITS / DIGIT_BITS;
    localparam int STEP_BITS  = $clog2(DIGITS);
    localparam int MISS_BITS  = 16;
    localparam int TIME_BITS  = 32;

    localparam logic [TIME_BITS-1:0] HIT_COST  = TIME_BITS'(4);
    localparam logic [TIME_BITS-1:0] MISS_COST = TIME_BITS'(14);
    localparam logic [CFG_BITS-1:0]  FRAME_COUNT_RESET = CFG_BITS'(4);

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    // clamp the configured frame count into 1..FRAMES
    function automatic logic [CNT_BITS-1:0] active_of(input logic [CFG_BITS-1:0] cnt);
        logic [CNT_BITS-1:0] res;
        if (cnt == '0) begin
            res = CNT_BITS'(1);
        end else if (32'(cnt) > FRAMES) begin
            res = CNT_BITS'(FRAMES);
        end else begin
            res = CNT_BITS'(cnt);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/rpr_ctrl.sv
`timescale 1ns / 1ps

module rpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rpr_pkg::t_status i_status,
    output rpr_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CALC   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [rpr_pkg::STEP_BITS-1:0] r_step, n_step;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.step = 1'b1;
                if (r_step == rpr_pkg::STEP_BITS'(rpr_pkg::DIGITS - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_COMMIT: begin
                // hold until the output register can take the word
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

>>> hw/rtl/rpr_datapath.sv
`timescale 1ns / 1ps

module rpr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpr_pkg::CFG_BITS-1:0]      i_cfg_wdata,
    input  logic                              i_action,
    input  logic [rpr_pkg::PAGE_BITS-1:0]     i_page,
    input  logic [rpr_pkg::RND_BITS-1:0]      i_random_value,
    input  rpr_pkg::t_cmd                     i_cmd,
    output rpr_pkg::t_status                  o_status,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic [2:0]                        o_frame,
    output logic [rpr_pkg::MISS_BITS-1:0]     o_miss_total,
    output logic [rpr_pkg::TIME_BITS-1:0]     o_time_total,
    output logic [3:0]                        o_occupied
);

    localparam int FB = rpr_pkg::FRAME_BITS;
    localparam int CB = rpr_pkg::CNT_BITS;
    localparam int XB = FB + rpr_pkg::DIGIT_BITS;

    logic [rpr_pkg::CFG_BITS-1:0]  r_frame_count;
    logic [rpr_pkg::PAGE_BITS-1:0] r_table [rpr_pkg::FRAMES];
    logic [CB-1:0]                 r_filled;
    logic [rpr_pkg::MISS_BITS-1:0] r_miss;
    logic [rpr_pkg::TIME_BITS-1:0] r_time;

    logic                          r_action;
    logic [rpr_pkg::PAGE_BITS-1:0] r_page;
    logic [rpr_pkg::RND_BITS-1:0]  r_rnd;
    logic [CB-1:0]                 r_active;
    logic [FB-1:0]                 r_rem;

    logic                          r_out_valid;
    logic                          r_hit;
    logic [2:0]                    r_frame;
    logic [rpr_pkg::MISS_BITS-1:0] r_miss_out;
    logic [rpr_pkg::TIME_BITS-1:0] r_time_out;
    logic [3:0]                    r_occ_out;

    // one nibble of the random value per step: rem = (rem*16 + nibble) mod active
    logic [XB-1:0] mod_x;
    logic [XB-1:0] mod_sub;
    logic [XB-1:0] mod_diff;
    logic [7:0]    mult_k;

    always_comb begin
        mod_x   = {r_rem, r_rnd[rpr_pkg::RND_BITS-1 -: rpr_pkg::DIGIT_BITS]};
        mod_sub = '0;
        mult_k  = '0;
        for (int k = 1; k < (1 << rpr_pkg::DIGIT_BITS); k++) begin
            mult_k = 8'(k) * 8'(r_active);
            if (mult_k <= 8'(mod_x)) begin
                mod_sub = XB'(mult_k);
            end
        end
        mod_diff = mod_x - mod_sub;
    end

    // lookup among filled frames, lowest match wins
    logic                            hit_found;
    logic [FB-1:0]                   hit_where;
    logic                            miss_append;
    logic [FB-1:0]                   miss_where;
    logic [FB-1:0]                   where;
    logic [rpr_pkg::TIME_BITS:0]     time_sum;
    logic [rpr_pkg::TIME_BITS-1:0]   time_next;
    logic [rpr_pkg::MISS_BITS-1:0]   miss_next;
    logic [CB-1:0]                   filled_next;

    always_comb begin
        hit_found = 1'b0;
        hit_where = '0;
        for (int i = rpr_pkg::FRAMES - 1; i >= 0; i--) begin
            if (CB'(i) < r_filled && r_table[i] == r_page) begin
                hit_found = 1'b1;
                hit_where = FB'(i);
            end
        end
        miss_append = (r_filled < r_active);
        miss_where  = miss_append ? FB'(r_filled) : r_rem;
        where       = hit_found ? hit_where : miss_where;

        time_sum  = {1'b0, r_time} + {1'b0, (hit_found ? rpr_pkg::HIT_COST
                                                        : rpr_pkg::MISS_COST)};
        time_next = time_sum[rpr_pkg::TIME_BITS] ? '1 : time_sum[rpr_pkg::TIME_BITS-1:0];

        miss_next   = r_miss;
        filled_next = r_filled;
        if (!hit_found) begin
            if (r_miss != '1) begin
                miss_next = r_miss + 1'b1;
            end
            if (miss_append) begin
                filled_next = r_filled + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= rpr_pkg::FRAME_COUNT_RESET;
            r_filled      <= '0;
            r_miss        <= '0;
            r_time        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_action == rpr_pkg::ACT_CLEAR) begin
                    r_filled <= '0;
                    r_miss   <= '0;
                    r_time   <= '0;
                end else begin
                    r_filled <= filled_next;
                    r_miss   <= miss_next;
                    r_time   <= time_next;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_page   <= i_page;
            r_rnd    <= i_random_value;
            r_active <= rpr_pkg::active_of(r_frame_count);
            r_rem    <= '0;
        end
        if (i_cmd.step) begin
            r_rnd <= r_rnd << rpr_pkg::DIGIT_BITS;
            r_rem <= FB'(mod_diff);
        end
        if (i_cmd.commit) begin
            if (r_action == rpr_pkg::ACT_CLEAR) begin
                r_hit      <= 1'b0;
                r_frame    <= '0;
                r_miss_out <= '0;
                r_time_out <= '0;
                r_occ_out  <= '0;
            end else begin
                if (!hit_found) begin
                    r_table[where] <= r_page;
                end
                r_hit      <= hit_found;
                r_frame    <= 3'(where);
                r_miss_out <= miss_next;
                r_time_out <= time_next;
                r_occ_out  <= 4'(filled_next);
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_ready;
    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_frame      = r_frame;
    assign o_miss_total = r_miss_out;
    assign o_time_total = r_time_out;
    assign o_occupied   = r_occ_out;

endmodule

>>> hw/rtl/random_page_replacement.sv
`timescale 1ns / 1ps
// Fully associative page-frame table with random replacement.
// Input channel (i_valid/o_ready) takes one word: i_action (0 access, 1 clear),
// i_page and i_random_value. Output channel (o_valid/i_ready) returns one word
// per input: hit flag, frame now holding the page, miss and time totals and
// the number of filled frames.
// The victim index is random_value mod active frames, worked out one 4-bit
// digit per cycle; the tag compare and all counter updates then follow
// together in the commit state, once the output register is free.
// A new word is taken only after the previous one has committed; o_ready is
// high only while the controller is idle.
// A finished word sits in the output register; if the receiver stalls, the
// next word is still accepted and computed, and it waits in its final cycle
// until the output register is free.
// i_cfg_we writes frame_count (0 acts as 1, above 8 acts as 8); it applies to
// words accepted afterwards. Reset (synchronous, active low) empties the
// table, clears both counters and sets frame_count to 4.
module random_page_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpr_pkg::CFG_BITS-1:0]      i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [rpr_pkg::PAGE_BITS-1:0]     i_page,
    input  logic [rpr_pkg::RND_BITS-1:0]      i_random_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic [2:0]                        o_frame,
    output logic [rpr_pkg::MISS_BITS-1:0]     o_miss_total,
    output logic [rpr_pkg::TIME_BITS-1:0]     o_time_total,
    output logic [3:0]                        o_occupied
);

    rpr_pkg::t_cmd    cmd;
    rpr_pkg::t_status status;

    rpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rpr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_page         (i_page),
        .i_random_value (i_random_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_frame        (o_frame),
        .o_miss_total   (o_miss_total),
        .o_time_total   (o_time_total),
        .o_occupied     (o_occupied)
    );

endmodule

>>> test/random_page_replacement_test.sv
`timescale 1ns / 1ps

module random_page_replacement_test;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 40;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 75;

    typedef struct packed {
        logic                          hit;
        logic [2:0]                    frame;
        logic [rpr_pkg::MISS_BITS-1:0] miss_total;
        logic [rpr_pkg::TIME_BITS-1:0] time_total;
        logic [3:0]                    occupied;
    } t_page_result;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic                          action;
        logic [rpr_pkg::PAGE_BITS-1:0] page;
        logic [rpr_pkg::RND_BITS-1:0]  rnd;
        logic [rpr_pkg::CFG_BITS-1:0]  cfg;
        logic                          typed;
        t_page_result                  want;
    } t_script_row;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [rpr_pkg::CFG_BITS-1:0]   i_cfg_wdata    = '0;
    logic                           i_valid        = 1'b0;
    logic                           o_ready;
    logic                           i_action       = rpr_pkg::ACT_ACCESS;
    logic [rpr_pkg::PAGE_BITS-1:0]  i_page         = '0;
    logic [rpr_pkg::RND_BITS-1:0]   i_random_value = '0;
    logic                           o_valid;
    logic                           i_ready        = 1'b0;
    logic                           o_hit;
    logic [2:0]                     o_frame;
    logic [rpr_pkg::MISS_BITS-1:0]  o_miss_total;
    logic [rpr_pkg::TIME_BITS-1:0]  o_time_total;
    logic [3:0]                     o_occupied;

    // shadow copy of the frame table
    logic [rpr_pkg::PAGE_BITS-1:0]  tbl_page [rpr_pkg::FRAMES];
    logic [3:0]                     tbl_filled = '0;
    logic [rpr_pkg::MISS_BITS-1:0]  faults     = '0;
    logic [rpr_pkg::TIME_BITS-1:0]  cost_total = '0;
    logic [rpr_pkg::CFG_BITS-1:0]   frames_cfg = rpr_pkg::FRAME_COUNT_RESET;

    t_page_result          pending_results [$];
    t_script_row           script [$];
    int                    fail_count   = 0;
    int                    results_seen = 0;
    int unsigned           cycle_count  = 0;

    random_page_replacement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_page         (i_page),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_frame        (o_frame),
        .o_miss_total   (o_miss_total),
        .o_time_total   (o_time_total),
        .o_occupied     (o_occupied)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void add_time(input logic [rpr_pkg::TIME_BITS-1:0] amount);
        if (cost_total > '1 - amount) begin
            cost_total = '1;
        end else begin
            cost_total = cost_total + amount;
        end
    endfunction

    // one access or clear against the shadow table
    function automatic t_page_result access_table(input logic action,
                                                  input logic [rpr_pkg::PAGE_BITS-1:0] page,
                                                  input logic [rpr_pkg::RND_BITS-1:0] rnd);
        t_page_result r;
        int           active;
        bit           found;
        r = '0;
        found = 1'b0;
        if (action == rpr_pkg::ACT_CLEAR) begin
            tbl_filled = '0;
            faults     = '0;
            cost_total = '0;
        end else begin
            active = (frames_cfg == 0) ? 1
                   : ((int'(frames_cfg) > rpr_pkg::FRAMES) ? rpr_pkg::FRAMES
                                                           : int'(frames_cfg));
            // lookup spans all filled frames, even above a lowered count
            for (int i = 0; i < rpr_pkg::FRAMES; i++) begin
                if (!found && i < int'(tbl_filled) && tbl_page[i] == page) begin
                    found   = 1'b1;
                    r.frame = 3'(i);
                end
            end
            if (found) begin
                r.hit = 1'b1;
                add_time(rpr_pkg::HIT_COST);
            end else begin
                if (int'(tbl_filled) < active) begin
                    r.frame = 3'(tbl_filled);
                    tbl_page[3'(tbl_filled)] = page;
                    tbl_filled = tbl_filled + 4'd1;
                end else begin
                    r.frame = 3'(int'(rnd) % active);
                    tbl_page[3'(int'(rnd) % active)] = page;
                end
                if (faults != '1) begin
                    faults = faults + 16'd1;
                end
                add_time(rpr_pkg::MISS_COST);
            end
        end
        r.miss_total = faults;
        r.time_total = cost_total;
        r.occupied   = tbl_filled;
        return r;
    endfunction

    // mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_word(input logic action,
                                     input logic [rpr_pkg::PAGE_BITS-1:0] page,
                                     input logic [rpr_pkg::RND_BITS-1:0] rnd);
        t_script_row row;
        row        = '0;
        row.kind   = ROW_WORD;
        row.action = action;
        row.page   = page;
        row.rnd    = rnd;
        script.push_back(row);
    endfunction

    function automatic void add_checked(input logic action,
                                        input logic [rpr_pkg::PAGE_BITS-1:0] page,
                                        input logic [rpr_pkg::RND_BITS-1:0] rnd,
                                        input logic hit,
                                        input logic [2:0] frame,
                                        input logic [rpr_pkg::MISS_BITS-1:0] misses,
                                        input logic [rpr_pkg::TIME_BITS-1:0] cost,
                                        input logic [3:0] occupied);
        t_script_row row;
        row        = '0;
        row.kind   = ROW_WORD;
        row.action = action;
        row.page   = page;
        row.rnd    = rnd;
        row.typed  = 1'b1;
        row.want   = '{hit, frame, misses, cost, occupied};
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [rpr_pkg::CFG_BITS-1:0] value);
        t_script_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.cfg  = value;
        script.push_back(row);
    endfunction

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    task automatic send_word(input logic action, input logic [rpr_pkg::PAGE_BITS-1:0] page,
                             input logic [rpr_pkg::RND_BITS-1:0] rnd, input logic typed,
                             input t_page_result want);
        int           gap;
        t_page_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= action;
        i_page         <= page;
        i_random_value <= rnd;
        do @(posedge i_clk); while (!o_ready);
        predicted = access_table(action, page, rnd);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_frame_count(input logic [rpr_pkg::CFG_BITS-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        frames_cfg  = value;
    endtask

    // receiver: random stalls plus one long hold-off so the block backs up
    initial begin
        t_page_result want;
        int           gap;
        bit           held_off;
        held_off = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                report("unexpected word", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit)               report("hit", want.hit, o_hit);
                if (o_frame !== want.frame)           report("frame", want.frame, o_frame);
                if (o_miss_total !== want.miss_total) report("miss_total", want.miss_total,
                                                             o_miss_total);
                if (o_time_total !== want.time_total) report("time_total", want.time_total,
                                                             o_time_total);
                if (o_occupied !== want.occupied)     report("occupied", want.occupied,
                                                             o_occupied);
            end
            if (!held_off && results_seen == HOLD_AT) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin
        int                            active;
        int                            pool;
        logic [rpr_pkg::PAGE_BITS-1:0] base;
        logic [rpr_pkg::PAGE_BITS-1:0] page;
        logic                          action;

        // after reset, frame count 4
        add_checked(rpr_pkg::ACT_ACCESS, 8'h00, 16'h0000, 1'b0, 3'd0, 16'd1, 32'd14, 4'd1);
        add_checked(rpr_pkg::ACT_ACCESS, 8'h00, 16'hFFFF, 1'b1, 3'd0, 16'd1, 32'd18, 4'd1);
        add_checked(rpr_pkg::ACT_ACCESS, 8'hFF, 16'hFFFF, 1'b0, 3'd1, 16'd2, 32'd32, 4'd2);
        add_checked(rpr_pkg::ACT_ACCESS, 8'hFF, 16'h0000, 1'b1, 3'd1, 16'd2, 32'd36, 4'd2);
        add_word(rpr_pkg::ACT_ACCESS, 8'h01, 16'h1234);
        add_word(rpr_pkg::ACT_ACCESS, 8'h02, 16'h4321);
        add_word(rpr_pkg::ACT_ACCESS, 8'h03, 16'hFFFF);      // table full: random victim
        add_word(rpr_pkg::ACT_ACCESS, 8'h04, 16'h0000);
        add_checked(rpr_pkg::ACT_CLEAR, 8'hFF, 16'hFFFF, 1'b0, 3'd0, 16'd0, 32'd0, 4'd0);
        add_cfg(4'd0);                                        // zero acts as one frame
        add_checked(rpr_pkg::ACT_ACCESS, 8'h10, 16'h1234, 1'b0, 3'd0, 16'd1, 32'd14, 4'd1);
        add_checked(rpr_pkg::ACT_ACCESS, 8'h11, 16'hFFFF, 1'b0, 3'd0, 16'd2, 32'd28, 4'd1);
        add_word(rpr_pkg::ACT_ACCESS, 8'h10, 16'h0001);
        add_cfg(4'd15);                                       // clamps to eight frames
        add_word(rpr_pkg::ACT_ACCESS, 8'h55, 16'h0000);
        add_word(rpr_pkg::ACT_ACCESS, 8'hAA, 16'h8000);
        add_word(rpr_pkg::ACT_ACCESS, 8'h0F, 16'h00FF);
        add_word(rpr_pkg::ACT_ACCESS, 8'hF0, 16'hFF00);
        add_word(rpr_pkg::ACT_ACCESS, 8'h33, 16'h5555);
        add_word(rpr_pkg::ACT_ACCESS, 8'hCC, 16'hAAAA);
        add_word(rpr_pkg::ACT_ACCESS, 8'h01, 16'h0F0F);
        add_word(rpr_pkg::ACT_ACCESS, 8'h80, 16'hFFFF);
        add_cfg(4'd3);                                        // lowered below the filled frames
        add_word(rpr_pkg::ACT_ACCESS, 8'hAA, 16'h0007);
        add_word(rpr_pkg::ACT_ACCESS, 8'h81, 16'hFFFF);
        add_checked(rpr_pkg::ACT_CLEAR, 8'h00, 16'h0000, 1'b0, 3'd0, 16'd0, 32'd0, 4'd0);
        add_cfg(4'd8);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                set_frame_count(script[k].cfg);
            end else begin
                send_word(script[k].action, script[k].page, script[k].rnd, script[k].typed,
                          script[k].want);
            end
        end

        // random phases; pages mostly from a small pool so hits and evictions mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 9))
                7:       set_frame_count(4'd0);
                8, 9:    set_frame_count(4'($urandom_range(9, 15)));
                default: set_frame_count(4'($urandom_range(1, 8)));
            endcase
            active = (frames_cfg == 0) ? 1
                   : ((int'(frames_cfg) > rpr_pkg::FRAMES) ? rpr_pkg::FRAMES
                                                           : int'(frames_cfg));
            pool = active + $urandom_range(0, 4);
            base = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
                send_word(rpr_pkg::ACT_CLEAR, 8'($urandom), 16'($urandom), 1'b0, '0);
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                action = ($urandom_range(0, 39) == 0) ? rpr_pkg::ACT_CLEAR
                                                      : rpr_pkg::ACT_ACCESS;
                if ($urandom_range(0, 3) == 0) begin
                    page = 8'($urandom_range(0, 255));
                end else begin
                    page = base + 8'($urandom_range(0, pool - 1));
                end
                send_word(action, page, 16'($urandom_range(0, 65535)), 1'b0, '0);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> random_page_replacement.f
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_ctrl.sv
hw/rtl/rpr_datapath.sv
hw/rtl/random_page_replacement.sv
test/random_page_replacement_test.sv
